// ----- src/assert_macros.svh -----
// Assertion macros shared by the step sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/stepseq_pkg.sv -----
// Shared types, constants and the semitone table of the step sequencer.
`default_nettype none
package stepseq_pkg;

	localparam int MAX_STEPS_DEF      = 32;
	localparam int BUFFER_SAMPLES_DEF = 512;
	localparam int MAX_ROWS_DEF       = 24;

	localparam int SPS_W   = 20;
	localparam int STEPS_W = 6;
	localparam int ROWS_W  = 5;
	localparam int COL_W   = 5;
	localparam int PITCH_W = 6;
	localparam int VEL_W   = 8;
	localparam int START_W = 16;
	localparam int CUR_W   = 5;
	localparam int FREQ_W  = 18;
	localparam int LEN_W   = 12;
	localparam int ENTRY_W = PITCH_W + VEL_W;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd2;

	localparam logic [SPS_W-1:0]   SPS_RESET   = 20'd24000;
	localparam logic [SPS_W-1:0]   SPS_MIN     = 20'd64;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd16;
	localparam logic [STEPS_W-1:0] STEPS_MIN   = 6'd4;
	localparam logic [ROWS_W-1:0]  ROWS_RESET  = 5'd12;
	localparam logic [ROWS_W-1:0]  ROWS_MIN    = 5'd12;

	localparam logic [PITCH_W-1:0] REST_CODE       = 6'h3F;
	localparam logic [VEL_W-1:0]   TOGGLE_VELOCITY = 8'd179;
	localparam logic [FREQ_W-1:0]  FREQ_MAX        = 18'd262143;

	typedef enum logic [1:0] {
		OP_TOGGLE = 2'd0,
		OP_WRITE  = 2'd1,
		OP_RENDER = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic out_single;
		logic acc;
		logic out_seg;
		logic write_entry;
		logic toggle_write;
		logic div_step;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic col_ok;
		logic row_ok;
		logic div_last;
		logic out_last;
	} sts_t;

	function automatic logic [FREQ_W-1:0] semitone_freq(input logic [4:0] k);
		logic [FREQ_W-1:0] f;
		unique case (k)
			5'd0:    f = 18'd56320;
			5'd1:    f = 18'd59669;
			5'd2:    f = 18'd63217;
			5'd3:    f = 18'd66976;
			5'd4:    f = 18'd70959;
			5'd5:    f = 18'd75178;
			5'd6:    f = 18'd79649;
			5'd7:    f = 18'd84385;
			5'd8:    f = 18'd89402;
			5'd9:    f = 18'd94719;
			5'd10:   f = 18'd100351;
			5'd11:   f = 18'd106318;
			5'd12:   f = 18'd112640;
			5'd13:   f = 18'd119338;
			5'd14:   f = 18'd126434;
			5'd15:   f = 18'd133952;
			5'd16:   f = 18'd141918;
			5'd17:   f = 18'd150356;
			5'd18:   f = 18'd159297;
			5'd19:   f = 18'd168769;
			5'd20:   f = 18'd178805;
			5'd21:   f = 18'd189437;
			5'd22:   f = 18'd200702;
			5'd23:   f = 18'd212636;
			5'd24:   f = 18'd225280;
			5'd25:   f = 18'd238676;
			5'd26:   f = 18'd252868;
			default: f = FREQ_MAX;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

// ----- src/stepseq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module stepseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- src/stepseq_ctrl.sv -----
// Control state machine that sequences requests through the step sequencer datapath.
`default_nettype none
`include "assert_macros.svh"
module stepseq_ctrl
	import stepseq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TOGGLE,
		ST_EMIT,
		ST_DIV,
		ST_SEG_RD,
		ST_SEG,
		ST_EMIT_SEG
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   m_tvalid_q;

	assign s_tready = in_ready_q;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (sts.op)
						OP_TOGGLE: begin
							if (sts.col_ok && sts.row_ok) begin
								state_q <= ST_TOGGLE;
							end else begin
								m_tvalid_q <= 1'b1;
								state_q    <= ST_EMIT;
							end
						end
						OP_RENDER: begin
							state_q <= ST_DIV;
						end
						OP_WRITE, OP_NONE: begin
							m_tvalid_q <= 1'b1;
							state_q    <= ST_EMIT;
						end
					endcase
				end
				ST_TOGGLE: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						in_ready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_SEG_RD;
					end
				end
				ST_SEG_RD: begin
					state_q <= ST_SEG;
				end
				ST_SEG: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_EMIT_SEG;
				end
				ST_EMIT_SEG: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (sts.out_last) begin
							in_ready_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_SEG;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && s_tvalid && in_ready_q;
		unique case (state_q)
			ST_DECODE: begin
				cmd.write_entry = (sts.op == OP_WRITE) && sts.col_ok;
				cmd.acc         = (sts.op == OP_WRITE) && sts.col_ok;
				cmd.out_single  = (sts.op == OP_WRITE) || (sts.op == OP_NONE) ||
					((sts.op == OP_TOGGLE) && !(sts.col_ok && sts.row_ok));
			end
			ST_TOGGLE: begin
				cmd.toggle_write = 1'b1;
				cmd.out_single   = 1'b1;
				cmd.acc          = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_SEG: begin
				cmd.out_seg = 1'b1;
			end
			default: begin
			end
		endcase
	end

	`ASSERT_IMPLY(a_one_side_open, clk, arst_n, m_tvalid_q, !in_ready_q)

endmodule
`default_nettype wire

// ----- src/stepseq_dp.sv -----
// Datapath: configuration registers, step table, remainder unit and result register.
`default_nettype none
`include "assert_macros.svh"
module stepseq_dp
	import stepseq_pkg::*;
#(
	parameter int MAX_STEPS      = MAX_STEPS_DEF,
	parameter int BUFFER_SAMPLES = BUFFER_SAMPLES_DEF,
	parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [SPS_W-1:0]      cfg_data,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast
);

	localparam int AW = $clog2(MAX_STEPS);
	localparam int FW = $clog2(BUFFER_SAMPLES + 1);
	localparam logic [FW-1:0] BUF_LEN = FW'(BUFFER_SAMPLES);

	// Configuration.
	logic [SPS_W-1:0]   sps_q;
	logic [STEPS_W-1:0] steps_q;
	logic [ROWS_W-1:0]  rows_q;
	logic [STEPS_W-1:0] steps_new;
	logic [ROWS_W-1:0]  rows_new;
	logic [SPS_W-1:0]   sps_new;

	// Captured request.
	op_t                op_q;
	logic [COL_W-1:0]   column_q;
	logic [COL_W-1:0]   row_q;
	logic [PITCH_W-1:0] pin_q;
	logic [VEL_W-1:0]   vin_q;
	logic [START_W-1:0] start_q;
	logic [SPS_W-1:0]   elapsed_q;

	// Render walk.
	logic [STEPS_W-1:0] rem_q;
	logic [3:0]         bit_cnt_q;
	logic [STEPS_W-1:0] cur_q;
	logic [STEPS_W-1:0] idx_q;
	logic [FW-1:0]      filled_q;
	logic               first_q;
	logic [SPS_W-1:0]   len0_q;

	// Step table.
	logic [MAX_STEPS-1:0] valid_q;
	logic                 vld_rd_q;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic                 we;
	logic [ENTRY_W-1:0]   wdata;
	logic [ENTRY_W-1:0]   rdata;
	logic [PITCH_W-1:0]   rd_pitch;
	logic [VEL_W-1:0]     rd_vel;
	logic [ROWS_W-1:0]    tgl_pitch;

	// Result register.
	logic               out_acc_q;
	logic [CUR_W-1:0]   out_cur_q;
	logic [FREQ_W-1:0]  out_freq_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [VEL_W-1:0]   out_vel_q;
	logic               out_last_q;

	logic [STEPS_W:0]   trial;
	logic [STEPS_W-1:0] rem_next;
	logic [STEPS_W:0]   idx_inc;
	logic [FW-1:0]      remaining;
	logic [SPS_W-1:0]   cand;
	logic               seg_last;
	logic [FW-1:0]      seg_len;

	always_comb begin
		if (cfg_data[STEPS_W-1:0] < STEPS_MIN) begin
			steps_new = STEPS_MIN;
		end else if ({1'b0, cfg_data[STEPS_W-1:0]} > (STEPS_W + 1)'(MAX_STEPS)) begin
			steps_new = STEPS_W'(MAX_STEPS);
		end else begin
			steps_new = cfg_data[STEPS_W-1:0];
		end
		if (cfg_data[ROWS_W-1:0] < ROWS_MIN) begin
			rows_new = ROWS_MIN;
		end else if ({1'b0, cfg_data[ROWS_W-1:0]} > (ROWS_W + 1)'(MAX_ROWS)) begin
			rows_new = ROWS_W'(MAX_ROWS);
		end else begin
			rows_new = cfg_data[ROWS_W-1:0];
		end
		sps_new = (cfg_data < SPS_MIN) ? SPS_MIN : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q   <= SPS_RESET;
			steps_q <= STEPS_RESET;
			rows_q  <= ROWS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SPS:   sps_q   <= sps_new;
				REG_STEPS: steps_q <= steps_new;
				REG_ROWS:  rows_q  <= rows_new;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op_t'(s_tuser);
			column_q  <= s_tdata[4:0];
			row_q     <= s_tdata[9:5];
			pin_q     <= s_tdata[15:10];
			vin_q     <= s_tdata[23:16];
			start_q   <= s_tdata[39:24];
			elapsed_q <= s_tdata[59:40];
		end else if (cmd.div_step) begin
			start_q <= {start_q[START_W-2:0], 1'b0};
		end
	end

	// Bit-serial remainder of the start step by the step count.
	assign trial    = {rem_q, start_q[START_W-1]};
	assign rem_next = (trial >= {1'b0, steps_q}) ? STEPS_W'(trial - {1'b0, steps_q})
		: STEPS_W'(trial);
	assign idx_inc  = {1'b0, idx_q} + (STEPS_W + 1)'(1);

	assign remaining = BUF_LEN - filled_q;
	assign cand      = first_q ? len0_q : sps_q;
	assign seg_last  = cand >= SPS_W'(remaining);
	assign seg_len   = seg_last ? remaining : FW'(cand);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			first_q  <= 1'b0;
		end else if (cmd.div_step && (bit_cnt_q == 4'd15)) begin
			filled_q <= '0;
			first_q  <= 1'b1;
		end else if (cmd.out_seg) begin
			filled_q <= filled_q + seg_len;
			first_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q     <= '0;
			bit_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_next;
			bit_cnt_q <= bit_cnt_q + 4'd1;
			len0_q    <= (elapsed_q < sps_q) ? (sps_q - elapsed_q) : SPS_W'(1);
			if (bit_cnt_q == 4'd15) begin
				cur_q <= rem_next;
				idx_q <= rem_next;
			end
		end else if (cmd.out_seg) begin
			idx_q <= (idx_inc >= {1'b0, steps_q}) ? '0 : STEPS_W'(idx_inc);
		end
	end

	// Step table access.
	assign raddr     = (op_q == OP_TOGGLE) ? AW'(column_q) : AW'(idx_q);
	assign waddr     = AW'(column_q);
	assign we        = cmd.write_entry || cmd.toggle_write;
	assign rd_pitch  = vld_rd_q ? rdata[ENTRY_W-1:VEL_W] : REST_CODE;
	assign rd_vel    = vld_rd_q ? rdata[VEL_W-1:0] : '0;
	assign tgl_pitch = rows_q - ROWS_W'(1) - row_q;

	always_comb begin
		if (cmd.toggle_write) begin
			if (rd_pitch != {1'b0, tgl_pitch}) begin
				wdata = {1'b0, tgl_pitch, TOGGLE_VELOCITY};
			end else begin
				wdata = {REST_CODE, VEL_W'(0)};
			end
		end else begin
			wdata = {(pin_q[PITCH_W-1] ? REST_CODE : pin_q), vin_q};
		end
	end

	stepseq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_STEPS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= valid_q[raddr];
			if (cfg_wr_en && (cfg_index == REG_STEPS)) begin
				for (int i = 0; i < MAX_STEPS; i++) begin
					if ((STEPS_W + 1)'(i) >= {1'b0, steps_new}) begin
						valid_q[i] <= 1'b0;
					end
				end
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_single) begin
			out_acc_q  <= cmd.acc;
			out_cur_q  <= '0;
			out_freq_q <= '0;
			out_len_q  <= '0;
			out_vel_q  <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.out_seg) begin
			out_acc_q  <= 1'b1;
			out_cur_q  <= cur_q[CUR_W-1:0];
			out_freq_q <= rd_pitch[PITCH_W-1] ? '0 : semitone_freq(rd_pitch[4:0]);
			out_len_q  <= LEN_W'(seg_len);
			out_vel_q  <= rd_vel;
			out_last_q <= seg_last;
		end
	end

	assign m_tdata = {4'b0, out_vel_q, out_len_q, out_freq_q, out_cur_q, out_acc_q};
	assign m_tlast = out_last_q;

	assign sts.op       = op_q;
	assign sts.col_ok   = {1'b0, column_q} < steps_q;
	assign sts.row_ok   = row_q < rows_q;
	assign sts.div_last = (bit_cnt_q == 4'd15);
	assign sts.out_last = out_last_q;

	`ASSERT_IMPLY(a_fill_bound, clk, arst_n, 1'b1, filled_q <= BUF_LEN)
	`ASSERT_NEXT(a_seg_nonzero, clk, arst_n, cmd.out_seg, out_len_q != '0)

endmodule
`default_nettype wire

// ----- src/step_sequencer_note_scheduler_top.sv -----
// Top level of the step sequencer note scheduler.
// A write or an unknown request is decoded and then gives its result; a valid toggle first
// rewrites its table entry. A render is decoded, runs the bit-serial remainder unit over every
// start bit, reads the table and loads the result before its first segment is offered; each
// later segment is loaded again after the previous one is taken.
// The next request can be accepted from the cycle after the last result is taken; reset restores the
// register defaults and clears the table's valid bits, so every step reads rest.
`default_nettype none
module step_sequencer_note_scheduler_top
	import stepseq_pkg::*;
#(
	parameter int MAX_STEPS      = MAX_STEPS_DEF,
	parameter int BUFFER_SAMPLES = BUFFER_SAMPLES_DEF,
	parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [SPS_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// column, row, pitch_in, velocity_in, start_step, elapsed_in_step, zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// op
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// accepted, current_step, frequency, segment_length, velocity_out, zero fill
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast
);

	cmd_t cmd;
	sts_t sts;

	stepseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stepseq_dp #(
		.MAX_STEPS      (MAX_STEPS),
		.BUFFER_SAMPLES (BUFFER_SAMPLES),
		.MAX_ROWS       (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
